// ===== hdl/dfe_pkg.sv =====
// Shared types and codes for the delimited field extractor.
package dfe_pkg;

    typedef enum logic [1:0] {
        PH_SEEK_START = 2'd0,
        PH_SEEK_END   = 2'd1,
        PH_DONE       = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [3:0] REG_START_MARKER = 4'd0;
    localparam logic [3:0] REG_START_LENGTH = 4'd1;
    localparam logic [3:0] REG_END_MARKER   = 4'd2;
    localparam logic [3:0] REG_END_LENGTH   = 4'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } result_t;

    // Up to two results from one item; r1 is only ever a status.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } pair_t;

endpackage

// ===== hdl/dfe_scan.sv =====
// Marker search state, byte window and per-item result generation.
module dfe_scan
    import dfe_pkg::*;
#(
    parameter int MARKER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    input  logic [63:0] start_marker,
    input  logic [3:0]  start_length,
    input  logic [63:0] end_marker,
    input  logic [3:0]  end_length,
    output pair_t       results
);

    localparam int WIN_W  = MARKER_BYTES * 8;
    localparam int FILL_W = $clog2(MARKER_BYTES + 1);

    phase_t              phase_reg, phase_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    logic [WIN_W-1:0]    win_shift;
    logic [FILL_W-1:0]   fill_inc, end_fill_adv;
    logic [FILL_W-1:0]   len_start, len_end;
    logic                term, in_start, in_end;
    logic                start_hit, end_hit, miss, emit_byte, has_status;
    result_t             byte_res, status_res;

    function automatic logic [7:0] win_byte(logic [WIN_W-1:0] win, logic [FILL_W-1:0] pos);
        logic [7:0] b;
        b = 8'd0;
        for (int i = 0; i < MARKER_BYTES; i++) begin
            if (pos == FILL_W'(i)) begin
                b = win[i*8 +: 8];
            end
        end
        return b;
    endfunction

    // Newest byte sits in byte 0, so marker byte i lines up with window byte len-1-i.
    function automatic logic marker_hit(logic [WIN_W-1:0] win, logic [FILL_W-1:0] fill,
                                        logic [63:0] marker, logic [FILL_W-1:0] len);
        logic hit;
        hit = (len != '0) && (fill >= len);
        for (int i = 0; i < MARKER_BYTES; i++) begin
            if (FILL_W'(i) < len) begin
                if (win_byte(win, len - FILL_W'(i) - FILL_W'(1)) != marker[i*8 +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    assign len_start = (start_length > 4'(MARKER_BYTES)) ? FILL_W'(MARKER_BYTES)
                                                         : start_length[FILL_W-1:0];
    assign len_end   = (end_length > 4'(MARKER_BYTES)) ? FILL_W'(MARKER_BYTES)
                                                       : end_length[FILL_W-1:0];

    assign term      = (text_byte == 8'd0);
    assign in_start  = (phase_reg == PH_SEEK_START);
    assign in_end    = (phase_reg == PH_SEEK_END);
    assign win_shift = WIN_W'({window_reg, text_byte});

    assign fill_inc     = (fill_reg < FILL_W'(MARKER_BYTES)) ? fill_reg + FILL_W'(1) : fill_reg;
    assign end_fill_adv = (fill_reg >= len_end) ? len_end : fill_reg + FILL_W'(1);

    assign start_hit = !term && in_start
                       && marker_hit(win_shift, fill_inc, start_marker, len_start);
    assign end_hit   = !term && in_end && (len_end != '0)
                       && marker_hit(win_shift, end_fill_adv, end_marker, len_end);
    assign miss      = (in_start || in_end) && !end_hit && (term || end_of_text);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            if (end_of_text) begin
                phase_next = PH_SEEK_START;
            end else begin
                unique case (phase_reg)
                    PH_SEEK_START: begin
                        if (miss) begin
                            phase_next = PH_DONE;
                        end else if (start_hit) begin
                            phase_next = PH_SEEK_END;
                        end
                    end
                    PH_SEEK_END: begin
                        if (end_hit || miss) begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: phase_next = PH_DONE;
                endcase
            end
        end
    end

    // window, fill and results
    always_comb begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (advance) begin
            if (start_hit || end_hit || miss || end_of_text) begin
                window_next = '0;
                fill_next   = '0;
            end else if (!term && in_start) begin
                window_next = win_shift;
                fill_next   = fill_inc;
            end else if (!term && in_end && (len_end != '0)) begin
                window_next = win_shift;
                fill_next   = end_fill_adv;
            end
        end

        // empty end marker passes bytes straight through
        emit_byte = !term && in_end && ((len_end == '0) || (fill_reg >= len_end));
        has_status = end_hit || miss;

        byte_res.data = (len_end == '0) ? text_byte
                                        : win_byte(window_reg, len_end - FILL_W'(1));
        byte_res.kind = KIND_BYTE;
        byte_res.last = 1'b0;

        status_res.data = 8'd0;
        status_res.kind = end_hit ? KIND_FOUND : KIND_MISS;
        status_res.last = 1'b1;

        results.count = {1'b0, emit_byte} + {1'b0, has_status};
        results.r0    = emit_byte ? byte_res : status_res;
        results.r1    = status_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEEK_START;
            window_reg <= '0;
            fill_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hdl/delimited_field_extractor_core.sv =====
// Flow: an accepted item waits in the input register until the result register can take
// a full pair; its results are then registered and presented on m_*.
// Throughput: one input item per cycle while m_tready is high; an item that yields
// two results (a text byte plus a status) holds the input side while the
// two-entry result register drains one item per cycle while m_tready is high.
// Reset: synchronous, active-low aresetn; clears markers, lengths, search state,
// byte window and both stage valids.
module delimited_field_extractor_core
    import dfe_pkg::*;
#(
    parameter int MARKER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] start_marker_reg, end_marker_reg;
    logic [3:0]  start_length_reg, end_length_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eot_reg;

    logic [1:0]  out_cnt_reg, out_cnt_next;
    result_t     out_r0_reg, out_r0_next;
    result_t     out_r1_reg, out_r1_next;

    logic        advance, pop;
    pair_t       results;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= '0;
            start_length_reg <= '0;
            end_marker_reg   <= '0;
            end_length_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_START_LENGTH: start_length_reg <= cfg_data[3:0];
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                REG_END_LENGTH:   end_length_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // the input register moves on once the result register can take a full pair
    assign pop      = m_tvalid && m_tready;
    assign advance  = in_valid_reg && ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_tready));
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    dfe_scan #(
        .MARKER_BYTES(MARKER_BYTES)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .text_byte    (in_byte_reg),
        .end_of_text  (in_eot_reg),
        .start_marker (start_marker_reg),
        .start_length (start_length_reg),
        .end_marker   (end_marker_reg),
        .end_length   (end_length_reg),
        .results      (results)
    );

    always_comb begin
        out_cnt_next = out_cnt_reg;
        out_r0_next  = out_r0_reg;
        out_r1_next  = out_r1_reg;
        if (advance) begin
            out_cnt_next = results.count;
            out_r0_next  = results.r0;
            out_r1_next  = results.r1;
        end else if (pop) begin
            out_cnt_next = out_cnt_reg - 2'd1;
            out_r0_next  = out_r1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 2'd0;
        end else begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_r0_reg <= out_r0_next;
        out_r1_reg <= out_r1_next;
    end

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = out_r0_reg.data;
    assign m_tuser  = out_r0_reg.kind;
    assign m_tlast  = out_r0_reg.last;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg != 2'd3)
        else $error("result register holds more than two items");

    a_pair_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_cnt_reg == 2'd2 && m_tready) |=> (out_cnt_reg == 2'd1))
        else $error("pair drain lost or refilled the second item");

    a_second_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_cnt_reg == 2'd2) |-> (out_r1_reg.last && out_r1_reg.kind != KIND_BYTE))
        else $error("second item of a pair is not a status");

    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_FOUND || m_tuser == KIND_MISS))
        else $error("closing item carries a byte kind");

    a_byte_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_BYTE) |-> !m_tlast)
        else $error("extracted byte flagged as closing item");
`endif

endmodule
